/* rtl/core/s2cd_pkg.sv */
// ----------------------------------------------------------------------------
// s2cd_pkg: shared constants, tables and types for seconds_to_calendar_date
// Reciprocal constants for the divide-by-constant steps, calendar tables and
// the pipeline flow-control bundle.
// ----------------------------------------------------------------------------
package s2cd_pkg;

   // Pipeline depth, the output register included
   localparam int NUM_STAGES = 9;

   // 86400 = 675 << 7: split off the low seven bits, divide the rest by 675
   localparam int             DAY_SHIFT   = 7;
   localparam logic [9:0]     DAY_ODD     = 10'd675;
   localparam logic [22:0]    DAY_RECIP   = 23'd6362914;  // floor(2^32 / 675)

   // Days in a four-year block (leap year first)
   localparam logic [10:0]    DAYS_FOUR_YEARS = 11'd1461;
   localparam logic [15:0]    QUAD_RECIP      = 16'd45933;  // floor(2^26 / 1461)

   // Time of day: 3600 = 225 << 4, 60 = 15 << 2
   localparam logic [11:0]    SECS_HOUR    = 12'd3600;
   localparam logic [12:0]    HOUR_RECIP   = 13'd4660;      // floor(2^20 / 225)
   localparam logic [5:0]     SECS_MINUTE  = 6'd60;
   localparam logic [12:0]    MINUTE_RECIP = 13'd4369;      // floor(2^16 / 15)

   localparam logic [11:0]    BASE_YEAR      = 12'd2000;
   localparam logic [11:0]    GREG_SKIP_YEAR = 12'd2100;    // not leap by Gregorian rule
   localparam logic [3:0]     MONTH_FEB      = 4'd2;
   localparam logic [2:0]     BASE_WEEKDAY   = 3'd6;        // 2000-01-01 was a Saturday
   localparam logic [3:0]     DAYS_WEEK      = 4'd7;

   // Day offset of each year inside a four-year block
   localparam logic [10:0] YEAR_START_DAYS [4] = '{11'd0, 11'd366, 11'd731, 11'd1096};

   // Days before each month
   localparam logic [8:0] DAYS_BEFORE_COMMON [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
   localparam logic [8:0] DAYS_BEFORE_LEAP [12] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};

   // Stage valid bits and load enables
   typedef struct packed {
      logic [NUM_STAGES-1:0] vld;
      logic [NUM_STAGES-1:0] en;
   } flow_type;

endpackage

/* rtl/core/s2cd_flow.sv */
// ----------------------------------------------------------------------------
// s2cd_flow: valid tracking and load enables for the conversion pipeline
// Each stage loads when it is empty or when the stage after it loads, so
// bubbles close up while the output is stalled.
// ----------------------------------------------------------------------------
module s2cd_flow (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                out_stall,
   output s2cd_pkg::flow_type  flow
);
   import s2cd_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] en;

   // Ripple the load enables back from the output
   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !out_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   // Advance valid bits with the data, hold them in stalled stages
   always_comb begin
      vld_in[0] = en[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign flow.vld = vld_ff;
   assign flow.en  = en;

endmodule

/* rtl/core/seconds_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// seconds_to_calendar_date: seconds since 2000-01-01 00:00:00 to date and time
// Pipelined converter giving year, month, day, hour, minute, second, weekday.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one 32-bit seconds count per transaction; the rsp
//   channel returns one calendar transaction for each, in order. Both channels
//   use valid/stall, and a transaction moves on an edge with valid high and
//   stall low.
//   The pipeline has nine register stages, the output register included.
//   Throughput is one transaction per cycle while rsp_stall is low; the
//   depth is set by the divide-by-constant steps (reciprocal multiply,
//   then multiply-back and correct), each cut by a register.
//   Every year divisible by four is leap, 2100 included; the weekday follows
//   the Gregorian rule, so it steps by one after February 2100.
//   Reset clears all stage valid bits; no result is offered after it.
//   When rsp_stall is high the output holds, upstream stages keep loading
//   until they fill, and req_stall rises only when stage one is full and
//   cannot move.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [31:0]  req_seconds_since_2000,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [11:0]  rsp_year,
   output logic [3:0]   rsp_month,
   output logic [4:0]   rsp_day,
   output logic [4:0]   rsp_hour,
   output logic [5:0]   rsp_minute,
   output logic [5:0]   rsp_second,
   output logic [2:0]   rsp_weekday
);
   import s2cd_pkg::*;

   typedef struct packed {
      logic [24:0] x;
      logic [6:0]  lo;
      logic [47:0] p;
   } st1_type;

   typedef struct packed {
      logic [24:0] x;
      logic [6:0]  lo;
      logic [15:0] q;
      logic [24:0] p;
   } st2_type;

   typedef struct packed {
      logic [15:0] days;
      logic [16:0] sod;
   } st3_type;

   typedef struct packed {
      logic [15:0] days;
      logic [16:0] sod;
      logic [31:0] pb;
      logic [24:0] ph;
      logic [2:0]  wd0;
   } st4_type;

   typedef struct packed {
      logic [15:0] days;
      logic [16:0] sod;
      logic [5:0]  qb;
      logic [4:0]  qh;
      logic [15:0] mb;
      logic [16:0] mh;
      logic [2:0]  wd0;
   } st5_type;

   typedef struct packed {
      logic [5:0]  blocks;
      logic [10:0] doff;
      logic [4:0]  hour;
      logic [11:0] rs;
      logic [2:0]  wd0;
   } st6_type;

   typedef struct packed {
      logic [11:0] year;
      logic [8:0]  yoff;
      logic        leap;
      logic [4:0]  hour;
      logic [11:0] rs;
      logic [21:0] pm;
      logic [2:0]  wd0;
   } st7_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [11:0] rs;
      logic [5:0]  qm;
      logic [11:0] m3;
      logic [2:0]  wd0;
   } st8_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } st9_type;

   flow_type flow;

   st1_type st1_in, st1_ff;
   st2_type st2_in, st2_ff;
   st3_type st3_in, st3_ff;
   st4_type st4_in, st4_ff;
   st5_type st5_in, st5_ff;
   st6_type st6_in, st6_ff;
   st7_type st7_in, st7_ff;
   st8_type st8_in, st8_ff;
   st9_type st9_in, st9_ff;

   logic [24:0] day_rem_full;
   logic [10:0] day_rem;
   logic [9:0]  day_rem_fix;
   logic [5:0]  oct_sum;
   logic [3:0]  oct_fold;
   logic [15:0] quad_rem;
   logic [16:0] hour_rem;
   logic [1:0]  yi;
   logic [8:0]  mon_base;
   logic [11:0] sec_rem;
   logic        greg_corr;
   logic [3:0]  wd_sum;

   s2cd_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_stall (rsp_stall),
      .flow      (flow)
   );

   assign req_stall = !flow.en[0];

   // Stage 1: estimate the day count from the seconds above bit 6
   always_comb begin
      st1_in.x  = req_seconds_since_2000[31:DAY_SHIFT];
      st1_in.lo = req_seconds_since_2000[DAY_SHIFT-1:0];
      st1_in.p  = 48'(st1_in.x) * 48'(DAY_RECIP);
   end

   // Stage 2: multiply the estimate back
   always_comb begin
      st2_in.x  = st1_ff.x;
      st2_in.lo = st1_ff.lo;
      st2_in.q  = st1_ff.p[47:32];
      st2_in.p  = 25'(25'(st2_in.q) * 25'(DAY_ODD));
   end

   // Stage 3: correct the day count, rebuild seconds of day
   always_comb begin
      day_rem_full = st2_ff.x - st2_ff.p;
      day_rem      = day_rem_full[10:0];
      if (day_rem >= 11'(DAY_ODD)) begin
         st3_in.days = st2_ff.q + 16'd1;
         day_rem_fix = 10'(day_rem - 11'(DAY_ODD));
      end else begin
         st3_in.days = st2_ff.q;
         day_rem_fix = day_rem[9:0];
      end
      st3_in.sod = {day_rem_fix, st2_ff.lo};
   end

   // Stage 4: estimate blocks and hours, fold the day count mod 7 by octal digits
   always_comb begin
      st4_in.days = st3_ff.days;
      st4_in.sod  = st3_ff.sod;
      st4_in.pb   = 32'(st3_ff.days) * 32'(QUAD_RECIP);
      st4_in.ph   = 25'(25'(st3_ff.sod[16:4]) * 25'(HOUR_RECIP));
      oct_sum     = 6'(st3_ff.days[2:0])   + 6'(st3_ff.days[5:3])
                  + 6'(st3_ff.days[8:6])   + 6'(st3_ff.days[11:9])
                  + 6'(st3_ff.days[14:12]) + 6'(st3_ff.days[15]);
      oct_fold    = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
      if (oct_fold >= DAYS_WEEK) begin
         st4_in.wd0 = 3'(oct_fold - DAYS_WEEK);
      end else begin
         st4_in.wd0 = oct_fold[2:0];
      end
   end

   // Stage 5: multiply block and hour estimates back
   always_comb begin
      st5_in.days = st4_ff.days;
      st5_in.sod  = st4_ff.sod;
      st5_in.qb   = st4_ff.pb[31:26];
      st5_in.qh   = st4_ff.ph[24:20];
      st5_in.mb   = 16'(st5_in.qb) * 16'(DAYS_FOUR_YEARS);
      st5_in.mh   = 17'(st5_in.qh) * 17'(SECS_HOUR);
      st5_in.wd0  = st4_ff.wd0;
   end

   // Stage 6: correct blocks and hours
   always_comb begin
      quad_rem = st5_ff.days - st5_ff.mb;
      if (quad_rem >= 16'(DAYS_FOUR_YEARS)) begin
         st6_in.blocks = st5_ff.qb + 6'd1;
         st6_in.doff   = 11'(quad_rem - 16'(DAYS_FOUR_YEARS));
      end else begin
         st6_in.blocks = st5_ff.qb;
         st6_in.doff   = quad_rem[10:0];
      end
      hour_rem = st5_ff.sod - st5_ff.mh;
      if (hour_rem >= 17'(SECS_HOUR)) begin
         st6_in.hour = st5_ff.qh + 5'd1;
         st6_in.rs   = 12'(hour_rem - 17'(SECS_HOUR));
      end else begin
         st6_in.hour = st5_ff.qh;
         st6_in.rs   = hour_rem[11:0];
      end
      st6_in.wd0 = st5_ff.wd0;
   end

   // Stage 7: pick the year in the block, estimate minutes
   always_comb begin
      if (st6_ff.doff >= YEAR_START_DAYS[3]) begin
         yi = 2'd3;
      end else if (st6_ff.doff >= YEAR_START_DAYS[2]) begin
         yi = 2'd2;
      end else if (st6_ff.doff >= YEAR_START_DAYS[1]) begin
         yi = 2'd1;
      end else begin
         yi = 2'd0;
      end
      st7_in.yoff = 9'(st6_ff.doff - YEAR_START_DAYS[yi]);
      st7_in.year = BASE_YEAR + {4'd0, st6_ff.blocks, 2'b00} + 12'(yi);
      st7_in.leap = (yi == 2'd0);
      st7_in.hour = st6_ff.hour;
      st7_in.rs   = st6_ff.rs;
      st7_in.pm   = 22'(22'(st6_ff.rs[11:2]) * 22'(MINUTE_RECIP));
      st7_in.wd0  = st6_ff.wd0;
   end

   // Stage 8: search the month table, multiply minutes back
   always_comb begin
      st8_in.month = 4'd0;
      for (int i = 1; i < 12; i++) begin
         if (st7_ff.yoff >= (st7_ff.leap ? DAYS_BEFORE_LEAP[i] : DAYS_BEFORE_COMMON[i])) begin
            st8_in.month = 4'(i);
         end
      end
      mon_base     = st7_ff.leap ? DAYS_BEFORE_LEAP[st8_in.month]
                                 : DAYS_BEFORE_COMMON[st8_in.month];
      st8_in.day   = 5'(st7_ff.yoff - mon_base + 9'd1);
      st8_in.month = st8_in.month + 4'd1;
      st8_in.year  = st7_ff.year;
      st8_in.hour  = st7_ff.hour;
      st8_in.rs    = st7_ff.rs;
      st8_in.qm    = st7_ff.pm[21:16];
      st8_in.m3    = 12'(st8_in.qm) * 12'(SECS_MINUTE);
      st8_in.wd0   = st7_ff.wd0;
   end

   // Stage 9: correct minutes, apply the Gregorian weekday shift
   always_comb begin
      sec_rem = st8_ff.rs - st8_ff.m3;
      if (sec_rem >= 12'(SECS_MINUTE)) begin
         st9_in.minute = st8_ff.qm + 6'd1;
         st9_in.second = 6'(sec_rem - 12'(SECS_MINUTE));
      end else begin
         st9_in.minute = st8_ff.qm;
         st9_in.second = sec_rem[5:0];
      end
      greg_corr = (st8_ff.year > GREG_SKIP_YEAR) ||
                  ((st8_ff.year == GREG_SKIP_YEAR) && (st8_ff.month > MONTH_FEB));
      wd_sum    = 4'(st8_ff.wd0) + 4'(BASE_WEEKDAY) - 4'(greg_corr);
      if (wd_sum >= DAYS_WEEK) begin
         st9_in.weekday = 3'(wd_sum - DAYS_WEEK);
      end else begin
         st9_in.weekday = wd_sum[2:0];
      end
      st9_in.year  = st8_ff.year;
      st9_in.month = st8_ff.month;
      st9_in.day   = st8_ff.day;
      st9_in.hour  = st8_ff.hour;
   end

   // Load each stage when the flow control lets it move
   always_ff @(posedge clock) begin
      if (flow.en[0]) begin
         st1_ff <= st1_in;
      end
      if (flow.en[1]) begin
         st2_ff <= st2_in;
      end
      if (flow.en[2]) begin
         st3_ff <= st3_in;
      end
      if (flow.en[3]) begin
         st4_ff <= st4_in;
      end
      if (flow.en[4]) begin
         st5_ff <= st5_in;
      end
      if (flow.en[5]) begin
         st6_ff <= st6_in;
      end
      if (flow.en[6]) begin
         st7_ff <= st7_in;
      end
      if (flow.en[7]) begin
         st8_ff <= st8_in;
      end
      if (flow.en[8]) begin
         st9_ff <= st9_in;
      end
   end

   assign rsp_valid   = flow.vld[NUM_STAGES-1];
   assign rsp_year    = st9_ff.year;
   assign rsp_month   = st9_ff.month;
   assign rsp_day     = st9_ff.day;
   assign rsp_hour    = st9_ff.hour;
   assign rsp_minute  = st9_ff.minute;
   assign rsp_second  = st9_ff.second;
   assign rsp_weekday = st9_ff.weekday;

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1))
      else $error("month or day out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour < 5'd24 && rsp_minute < 6'd60 && rsp_second < 6'd60))
      else $error("time of day out of range");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday < 3'd7))
      else $error("weekday out of range");

   a_no_stall_through: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

endmodule

/* sim/tb_seconds_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// tb_seconds_to_calendar_date: self-checking bench for the seconds-to-date core
// Walks a table of directed timestamps, then random ones biased toward year
// and month boundaries and the 2100 leap day. Every result transaction is
// compared field by field against a calendar computed in the bench, with
// random idle bursts on both channels, one long output hold-off and drains.
// ----------------------------------------------------------------------------
module tb_seconds_to_calendar_date;
   import s2cd_pkg::*;

   localparam int unsigned SECS_QUAD     = 126230400;
   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned FIRST_YEAR    = 2000;
   localparam int unsigned STAMP_2100_FEB28 = 32'd3160771200;
   localparam int          RANDOM_ITEMS  = 1330;
   localparam int          TAIL_ITEMS    = 150;
   localparam int          HOLD_CYCLES   = 60;
   localparam int          DIRECTED_ROWS = 24;

   localparam int unsigned YEAR_OFFSET [4] = '{0, 31622400, 63158400, 94694400};
   localparam int unsigned MONTH_OFFSET_COMMON [12] = '{
      0, 2678400, 5097600, 7776000, 10368000, 13046400,
      15638400, 18316800, 20995200, 23587200, 26265600, 28857600};
   localparam int unsigned MONTH_OFFSET_LEAP [12] = '{
      0, 2678400, 5184000, 7862400, 10454400, 13132800,
      15724800, 18403200, 21081600, 23673600, 26352000, 28944000};
   localparam int unsigned DAYS_AHEAD [12] = '{
      0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } cal_date_type;

   // One directed row: the stamp, whether the date is typed in, and the date
   typedef struct packed {
      logic [31:0]  stamp;
      logic         typed;
      cal_date_type want;
   } stamp_row_type;

   localparam cal_date_type NO_DATE = '0;

   localparam stamp_row_type DIRECTED [DIRECTED_ROWS] = '{
      {32'd0,          1'b1, {12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd6}},
      {32'd59,         1'b0, NO_DATE},
      {32'd60,         1'b0, NO_DATE},
      {32'd3599,       1'b0, NO_DATE},
      {32'd3600,       1'b0, NO_DATE},
      {32'd86399,      1'b0, NO_DATE},
      {32'd86400,      1'b0, NO_DATE},
      {32'd5183999,    1'b0, NO_DATE},   // 2000-02-29, last second
      {32'd5184000,    1'b0, NO_DATE},   // 2000-03-01, first second
      {32'd31622399,   1'b1, {12'd2000, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd0}},
      {32'd31622400,   1'b1, {12'd2001, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd1}},
      {32'd63158400,   1'b0, NO_DATE},
      {32'd94694400,   1'b0, NO_DATE},
      {32'd123552000,  1'b0, NO_DATE},   // December of a common year
      {32'd126230399,  1'b0, NO_DATE},
      {32'd126230400,  1'b0, NO_DATE},   // start of the second four-year block
      {32'd3160771200, 1'b0, NO_DATE},   // 2100-02-28
      {32'd3160857600, 1'b0, NO_DATE},   // 2100-02-29, leap by the date rule
      {32'd3160944000, 1'b0, NO_DATE},   // 2100-03-01, weekday shifts
      {32'h5555_5555,  1'b0, NO_DATE},
      {32'hAAAA_AAAA,  1'b0, NO_DATE},
      {32'h8000_0000,  1'b0, NO_DATE},
      {32'hFFFF_FFFE,  1'b0, NO_DATE},
      {32'hFFFF_FFFF,  1'b1, {12'd2136, 4'd2, 5'd6, 5'd6, 6'd28, 6'd15, 3'd1}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_seconds_since_2000 = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [2:0]  rsp_weekday;

   cal_date_type pending_dates [$];
   int        mismatches = 0;
   bit        quiet_tail = 1'b0;  // no idling on either side
   bit        steady_send = 1'b0; // sender offers back to back
   bit        hold_long = 1'b0;   // receiver holds off for HOLD_CYCLES

   seconds_to_calendar_date DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_seconds_since_2000 (req_seconds_since_2000),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_year               (rsp_year),
      .rsp_month              (rsp_month),
      .rsp_day                (rsp_day),
      .rsp_hour               (rsp_hour),
      .rsp_minute             (rsp_minute),
      .rsp_second             (rsp_second),
      .rsp_weekday            (rsp_weekday)
   );

   always #10 clock = ~clock;

   // Convert a stamp: four-year block, year in block, month, then division
   function automatic cal_date_type calendar_of(input logic [31:0] stamp);
      int unsigned  rest;
      int unsigned  quad;
      int unsigned  yr;
      int unsigned  yi;
      int unsigned  mi;
      int unsigned  boundary;
      int unsigned  prior;
      int unsigned  day_count;
      bit           greg_leap;
      cal_date_type d;
      rest = stamp;
      quad = rest / SECS_QUAD;
      rest = rest % SECS_QUAD;
      yi = 0;
      for (int i = 1; i < 4; i++)
         if (rest >= YEAR_OFFSET[i]) yi = i;
      rest -= YEAR_OFFSET[yi];
      yr = FIRST_YEAR + quad * 4 + yi;
      mi = 0;
      for (int i = 1; i < 12; i++) begin
         boundary = (yr % 4 == 0) ? MONTH_OFFSET_LEAP[i] : MONTH_OFFSET_COMMON[i];
         if (rest >= boundary) mi = i;
      end
      rest -= (yr % 4 == 0) ? MONTH_OFFSET_LEAP[mi] : MONTH_OFFSET_COMMON[mi];
      d.year   = yr[11:0];
      d.month  = 4'(mi + 1);
      d.day    = 5'(rest / SECS_PER_DAY + 1);
      rest     = rest % SECS_PER_DAY;
      d.hour   = 5'(rest / SECS_PER_HOUR);
      rest     = rest % SECS_PER_HOUR;
      d.minute = 6'(rest / 60);
      d.second = 6'(rest % 60);
      // Weekday by the Gregorian rule, independent of the date rule above
      prior = yr - 1;
      greg_leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
      day_count = d.day + DAYS_AHEAD[mi] + ((mi >= 2 && greg_leap) ? 1 : 0);
      d.weekday = 3'((prior + prior / 4 - prior / 100 + prior / 400 + day_count) % 7);
      return d;
   endfunction

   // Pick a random stamp: uniform, near year or month boundaries, near 2100-02-28 or near the top
   function automatic logic [31:0] next_stamp();
      int unsigned yr_idx;
      int unsigned base;
      int          delta;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      yr_idx = $urandom_range(0, 135);
      base = (yr_idx / 4) * SECS_QUAD + YEAR_OFFSET[yr_idx % 4];
      delta = $urandom_range(0, 4) - 2;
      case (kind)
         0, 1, 2, 3: return $urandom;
         4, 5: return 32'(base + delta);
         6, 7: begin
            base += (yr_idx % 4 == 0) ? MONTH_OFFSET_LEAP[$urandom_range(0, 11)]
                                      : MONTH_OFFSET_COMMON[$urandom_range(0, 11)];
            if ($urandom_range(0, 1)) delta = $urandom_range(0, 3 * SECS_PER_DAY);
            return 32'(base + delta);
         end
         8: return 32'(STAMP_2100_FEB28 + $urandom_range(0, 3 * SECS_PER_DAY));
         default: return 32'hFFFF_FFFF - $urandom_range(0, 100000);
      endcase
   endfunction

   // Offer one transaction at the falling edge, hold until accepted
   task automatic offer_stamp(input logic [31:0] stamp, input cal_date_type want);
      if (!quiet_tail && !steady_send && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_seconds_since_2000 = stamp;
      do @(posedge clock); while (req_stall);
      pending_dates.push_back(want);
      @(negedge clock);
   endtask

   task automatic drain_pending();
      req_valid = 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Stimulus: directed table, then random stamps with pressure phases
   initial begin
      logic [31:0] stamp;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int r = 0; r < DIRECTED_ROWS; r++)
         offer_stamp(DIRECTED[r].stamp,
                     DIRECTED[r].typed ? DIRECTED[r].want : calendar_of(DIRECTED[r].stamp));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 400) begin
            hold_long = 1'b1;
            steady_send = 1'b1;
         end
         if (n == 460) steady_send = 1'b0;
         if (n == 300 || n == 800) drain_pending();
         if (n == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
         stamp = next_stamp();
         offer_stamp(stamp, calendar_of(stamp));
      end
      drain_pending();
      repeat (NUM_STAGES + 8) @(negedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Receiver: random stall bursts, one long hold-off on request
   initial begin
      @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_long = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            @(negedge clock);
         end
      end
   end

   // Compare each accepted result against the oldest pending date
   always @(posedge clock) begin : compare_results
      cal_date_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dates.size() == 0) begin
            $error("result transaction with no pending date");
            mismatches++;
         end else begin
            want = pending_dates.pop_front();
            check_field("year", want.year, rsp_year);
            check_field("month", want.month, rsp_month);
            check_field("day", want.day, rsp_day);
            check_field("hour", want.hour, rsp_hour);
            check_field("minute", want.minute, rsp_minute);
            check_field("second", want.second, rsp_second);
            check_field("weekday", want.weekday, rsp_weekday);
         end
      end
   end

   // Watchdog
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
